/* src/sfe_pkg.sv */
package sfe_pkg;

  // default sizes
  localparam int unsigned SENDERS_DEF    = 256;
  localparam int unsigned DEST_DEPTH_DEF = 1024;
  localparam int unsigned MAX_FANOUT_DEF = 64;

  // fixed field widths
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned OFF_W   = 10;
  localparam int unsigned STAMP_W = 32;

  // func codes
  localparam logic [1:0] FUNC_SPIKE  = 2'd0;
  localparam logic [1:0] FUNC_SENDER = 2'd1;
  localparam logic [1:0] FUNC_DEST   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NET   = 2'd0;
  localparam logic [1:0] KIND_LOCAL = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // register indexes
  localparam logic REG_LOCAL_CLUSTER = 1'b0;

  typedef struct packed {
    logic [7:0]         sender_id;
    logic [CNT_W-1:0]   entry_count;
    logic               entry_local;
    logic [OFF_W-1:0]   entry_offset;
    logic [9:0]         dest_index;
    logic [7:0]         dest_cluster;
    logic [7:0]         dest_axon;
    logic [STAMP_W-1:0] stamp;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         source_cluster;
    logic [7:0]         out_cluster;
    logic [7:0]         out_axon;
    logic [STAMP_W-1:0] out_stamp;
    logic               last;
  } result_t;

endpackage

/* src/sfe_ram.sv */
module sfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/sfe_seq.sv */
module sfe_seq
  import sfe_pkg::*;
#(
  parameter int unsigned SENDERS    = SENDERS_DEF,
  parameter int unsigned DEST_DEPTH = DEST_DEPTH_DEF,
  parameter int unsigned MAX_FANOUT = MAX_FANOUT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  item_t      in_item,
  input  logic [7:0] local_cluster,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam int unsigned SAW = $clog2(SENDERS);
  localparam int unsigned DAW = $clog2(DEST_DEPTH);
  localparam int unsigned LW  = $clog2(MAX_FANOUT + 1);
  localparam int unsigned SEW = CNT_W + 1 + DAW;

  // reciprocals for the index wrap, fixed point with RCP_SH fraction bits
  localparam int unsigned RCP_SH  = 20;
  localparam logic [31:0] SID_RCP = 32'((64'd1 << RCP_SH) / SENDERS);
  localparam logic [31:0] DST_RCP = 32'((64'd1 << RCP_SH) / DEST_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // remainder of a narrow value by a constant: reciprocal quotient estimate
  // is low by at most one, so a single compare and subtract finishes it
  function automatic logic [31:0] rem10(input logic [9:0] v, input logic [31:0] m,
                                        input logic [31:0] rcp);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(v) * rcp) >> RCP_SH;
    r = 32'(v) - q * m;
    if (r >= m) begin
      r = r - m;
    end
    return r;
  endfunction

  function automatic logic [DAW-1:0] ptr_inc(input logic [DAW-1:0] p);
    return (p == DAW'(DEST_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t             state_r, state_nxt;
  logic [SAW-1:0]     clr_r, clr_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [LW-1:0]      left_r, left_nxt;
  logic               loc_r, loc_nxt;
  logic               zero_r, zero_nxt;
  logic [DAW-1:0]     ptr_r, ptr_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;

  logic               s_we, s_re;
  logic [SAW-1:0]     s_waddr, s_raddr;
  logic [SEW-1:0]     s_wdata, s_rdata;
  logic               d_we, d_re;
  logic [DAW-1:0]     d_waddr, d_raddr;
  logic [15:0]        d_wdata, d_rdata;

  logic [CNT_W-1:0]   e_cnt;
  logic               e_loc;
  logic [DAW-1:0]     e_off;
  logic [LW-1:0]      e_sat;
  logic               slot_free;
  logic               fin;
  logic [SAW-1:0]     sid_mod;
  logic [DAW-1:0]     off_mod;

  sfe_ram #(.WIDTH(SEW), .DEPTH(SENDERS)) u_sender_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sfe_ram #(.WIDTH(16), .DEPTH(DEST_DEPTH)) u_dest_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign sid_mod = SAW'(rem10({2'b00, in_item.sender_id}, 32'(SENDERS), SID_RCP));
  assign off_mod = DAW'(rem10(in_item.entry_offset, 32'(DEST_DEPTH), DST_RCP));

  assign e_cnt = s_rdata[SEW-1 -: CNT_W];
  assign e_loc = s_rdata[DAW];
  assign e_off = s_rdata[DAW-1:0];
  assign e_sat = (e_cnt > CNT_W'(MAX_FANOUT)) ? LW'(MAX_FANOUT) : LW'(e_cnt);

  assign slot_free = !out_valid_r || out_ready;
  assign fin       = (left_r == LW'(1));
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    stamp_nxt     = stamp_r;
    left_nxt      = left_r;
    loc_nxt       = loc_r;
    zero_nxt      = zero_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    s_we          = 1'b0;
    s_waddr       = clr_r;
    s_wdata       = '0;
    s_re          = 1'b0;
    s_raddr       = sid_mod;
    d_we          = 1'b0;
    d_waddr       = DAW'(rem10(in_item.dest_index, 32'(DEST_DEPTH), DST_RCP));
    d_wdata       = {in_item.dest_cluster, in_item.dest_axon};
    d_re          = 1'b0;
    d_raddr       = ptr_r;

    unique case (state_r)
      ST_CLEAR: begin
        s_we    = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SAW'(SENDERS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_SPIKE: begin
              s_re      = 1'b1;
              stamp_nxt = in_item.stamp;
              state_nxt = ST_LOOK;
            end
            FUNC_SENDER: begin
              s_we    = 1'b1;
              s_waddr = sid_mod;
              s_wdata = {in_item.entry_count, in_item.entry_local, off_mod};
            end
            FUNC_DEST: begin
              d_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        // first destination read goes out with the sender entry
        left_nxt  = e_sat;
        loc_nxt   = e_loc;
        zero_nxt  = (e_sat == '0);
        d_raddr   = e_off;
        d_re      = (e_sat != '0);
        ptr_nxt   = ptr_inc(e_off);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_res_nxt.source_cluster = local_cluster;
          out_res_nxt.out_stamp      = stamp_r;
          if (zero_r) begin
            out_res_nxt.kind        = KIND_ACK;
            out_res_nxt.out_cluster = 8'd0;
            out_res_nxt.out_axon    = 8'd0;
            out_res_nxt.last        = 1'b1;
            state_nxt               = ST_IDLE;
          end else begin
            out_res_nxt.kind        = (fin && loc_r) ? KIND_LOCAL : KIND_NET;
            out_res_nxt.out_cluster = d_rdata[15:8];
            out_res_nxt.out_axon    = d_rdata[7:0];
            out_res_nxt.last        = fin;
            left_nxt                = left_r - 1'b1;
            if (fin) begin
              state_nxt = ST_IDLE;
            end else begin
              d_re    = 1'b1;
              ptr_nxt = ptr_inc(ptr_r);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      left_r      <= '0;
      loc_r       <= 1'b0;
      zero_r      <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      left_r      <= left_nxt;
      loc_r       <= loc_nxt;
      zero_r      <= zero_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r   <= stamp_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // only the closing beat of a spike may be local or ack-only
  a_mid_is_net: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.last |-> out_res_r.kind == KIND_NET)
    else $error("non-final beat with non-network kind");

  // a fan-out run never starts with nothing left
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && !zero_r |-> left_r != '0)
    else $error("emit with empty destination count");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= LW'(MAX_FANOUT))
    else $error("destination count above fan-out limit");

  // a destination read in EMIT never runs past the final beat of a run
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && d_re |-> !fin && !zero_r)
    else $error("destination read past end of run");

  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && zero_r && slot_free |=> state_r == ST_IDLE)
    else $error("ack-only spike did not finish");

endmodule

/* src/spike_fanout_encoder_core.sv */
// Spike fan-out encoder. A spike beat (tuser = 0) names a sender; the block
// reads that sender's entry (count, local flag, offset) from the sender
// table and then walks the destination table from offset upward, wrapping
// at DEST_DEPTH, sending one result beat per destination. A count above
// MAX_FANOUT is clipped to MAX_FANOUT. If the local flag is set the final
// beat is a local-axon delivery (tuser = 1); a count of zero yields one
// ack-only beat (tuser = 2). tlast marks the final beat of each spike.
// Load beats (tuser = 1 sender entry, tuser = 2 destination entry) write a
// table and produce no output. A spike first looks up its sender entry in
// the sender table and then makes one destination-RAM read per beat on
// the single read port. Output stalls hold the walk. Results sit in an
// output register, so a new beat may be accepted while the last result
// still waits. After reset the sender table is zeroed by a clearing pass
// over all SENDERS entries, during which in_tready stays low; register
// writes are taken throughout. Destination entries must be written before
// a spike reaches them.
module spike_fanout_encoder_core
  import sfe_pkg::*;
#(
  parameter int unsigned SENDERS    = SENDERS_DEF,
  parameter int unsigned DEST_DEPTH = DEST_DEPTH_DEF,
  parameter int unsigned MAX_FANOUT = MAX_FANOUT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] sender_id, [14:8] entry_count, [15] entry_local,
  // [25:16] entry_offset, [35:26] dest_index, [43:36] dest_cluster,
  // [51:44] dest_axon, [83:52] stamp, [87:84] zero
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,   // [1:0] func

  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] source_cluster, [15:8] out_cluster, [23:16] out_axon,
  // [55:24] out_stamp
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last

  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] local_cluster_r, local_cluster_nxt;
  logic       reg_idx;
  item_t      item;
  result_t    res;

  // register block: one register, local_cluster at byte 0
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    local_cluster_nxt = local_cluster_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        reg_idx == REG_LOCAL_CLUSTER) begin
      local_cluster_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_cluster_r <= 8'd0;
    end else begin
      local_cluster_r <= local_cluster_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == REG_LOCAL_CLUSTER) ? {24'd0, local_cluster_r} : 32'd0;

  // unpack input beat
  assign item.sender_id    = in_tdata[7:0];
  assign item.entry_count  = in_tdata[14:8];
  assign item.entry_local  = in_tdata[15];
  assign item.entry_offset = in_tdata[25:16];
  assign item.dest_index   = in_tdata[35:26];
  assign item.dest_cluster = in_tdata[43:36];
  assign item.dest_axon    = in_tdata[51:44];
  assign item.stamp        = in_tdata[83:52];

  sfe_seq #(
    .SENDERS    (SENDERS),
    .DEST_DEPTH (DEST_DEPTH),
    .MAX_FANOUT (MAX_FANOUT)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser),
    .in_item       (item),
    .local_cluster (local_cluster_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_res       (res)
  );

  // pack result beat
  assign out_tdata = {res.out_stamp, res.out_axon, res.out_cluster, res.source_cluster};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
